// ===== rtl/core/bzs_pkg.sv =====
// Shared types and constants of the cubic Bezier sampler.
`default_nettype none
package bzs_pkg;

	localparam int T_W        = 17;
	localparam int WGT_W      = 49;
	localparam int IDX_W      = 6;
	localparam int NPTS_W     = 7;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 17;
	localparam int SPLIT_W    = 24;

	localparam logic [T_W-1:0] T_ONE = 17'h10000;

	localparam logic [NPTS_W-1:0] NPTS_RESET  = 7'd16;
	localparam logic [T_W-1:0]    TSTEP_RESET = 17'd4369;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_T_STEP     = 8'd1;

	typedef struct packed {
		logic             last;
		logic [IDX_W-1:0] idx;
	} bzs_tag_t;

	typedef struct packed {
		logic busy;
		logic fire;
		logic last;
	} bzs_seq_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/bzs_seq.sv =====
// Sample sequencer: holds the segment, counts samples and steps t.
`default_nettype none
module bzs_seq
	import bzs_pkg::*;
#(
	parameter int MAX_POINTS  = 64,
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_DATA_W-1:0]          cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [8*COORD_WIDTH-1:0]       in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [T_W-1:0]                      out_t,
	output bzs_tag_t                            out_tag,
	output logic [1:0][3:0][COORD_WIDTH-1:0]    out_pts,
	output bzs_seq_stat_t                       stat
);

	localparam logic [NPTS_W-1:0] N_MAX = NPTS_W'(MAX_POINTS);
	localparam logic [NPTS_W-1:0] N_MIN = NPTS_W'(2);

	logic [NPTS_W-1:0]                 num_points_q;
	logic [T_W-1:0]                    t_step_q;
	logic                              busy_q;
	logic [IDX_W-1:0]                  cnt_q;
	logic [T_W-1:0]                    t_acc_q;
	logic [1:0][3:0][COORD_WIDTH-1:0]  pts_q;

	logic [NPTS_W-1:0] n_lim;
	logic              last;
	logic              fire;
	logic              in_acc;
	logic [T_W:0]      t_sum;
	logic [T_W-1:0]    t_next;

	always_comb begin
		if (num_points_q < N_MIN) begin
			n_lim = N_MIN;
		end else if (num_points_q > N_MAX) begin
			n_lim = N_MAX;
		end else begin
			n_lim = num_points_q;
		end
	end

	assign last     = ({1'b0, cnt_q} == (n_lim - NPTS_W'(1)));
	assign fire     = busy_q && out_ready;
	assign in_ready = !busy_q || (fire && last);
	assign in_acc   = in_valid && in_ready;
	assign t_sum    = {1'b0, t_acc_q} + {1'b0, t_step_q};
	assign t_next   = (t_sum > {1'b0, T_ONE}) ? T_ONE : t_sum[T_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q <= NPTS_RESET;
			t_step_q     <= TSTEP_RESET;
			busy_q       <= 1'b0;
			cnt_q        <= '0;
			t_acc_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_NUM_POINTS: num_points_q <= cfg_data[NPTS_W-1:0];
					CFG_T_STEP:     t_step_q     <= cfg_data[T_W-1:0];
					default:        ;
				endcase
			end
			if (in_acc) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				t_acc_q <= '0;
			end else if (fire) begin
				if (last) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
				t_acc_q <= t_next;
			end
		end
	end

	// bias each coordinate to offset binary
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int k = 0; k < 4; k++) begin
				pts_q[0][k] <= in_data[(2*k)*COORD_WIDTH +: COORD_WIDTH]
					^ {1'b1, {(COORD_WIDTH-1){1'b0}}};
				pts_q[1][k] <= in_data[(2*k+1)*COORD_WIDTH +: COORD_WIDTH]
					^ {1'b1, {(COORD_WIDTH-1){1'b0}}};
			end
		end
	end

	assign out_valid    = busy_q;
	assign out_t        = last ? T_ONE : t_acc_q;
	assign out_tag.last = last;
	assign out_tag.idx  = cnt_q;
	assign out_pts      = pts_q;
	assign stat.busy    = busy_q;
	assign stat.fire    = fire;
	assign stat.last    = last;

endmodule
`default_nettype wire

// ===== rtl/core/bzs_weight.sv =====
// Three-stage pipeline forming the four Bernstein weights from t.
`default_nettype none
module bzs_weight
	import bzs_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [T_W-1:0]                    in_t,
	input  wire bzs_tag_t                          in_tag,
	input  wire logic [1:0][3:0][COORD_WIDTH-1:0]  in_pts,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [3:0][WGT_W-1:0]                  out_w,
	output bzs_tag_t                               out_tag,
	output logic [1:0][3:0][COORD_WIDTH-1:0]       out_pts
);

	localparam int SQ_W   = 2*T_W;
	localparam int CUBE_W = SQ_W + T_W;

	logic valid_s1, valid_s2, valid_s3;
	logic en_s1, en_s2, en_s3;

	logic [T_W-1:0]  u_s1, t_s1;
	logic [SQ_W-1:0] uu_s1, tt_s1;
	logic [WGT_W-1:0] a_s2, b_s2, c_s2, d_s2;
	logic [3:0][WGT_W-1:0] w_s3;

	bzs_tag_t tag_s1, tag_s2, tag_s3;
	logic [1:0][3:0][COORD_WIDTH-1:0] pts_s1, pts_s2, pts_s3;

	logic [T_W-1:0]    u_d;
	logic [CUBE_W-1:0] a_d, b_d, c_d, d_d;

	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	assign u_d = T_ONE - in_t;
	assign a_d = CUBE_W'(uu_s1) * CUBE_W'(u_s1);
	assign b_d = CUBE_W'(uu_s1) * CUBE_W'(t_s1);
	assign c_d = CUBE_W'(tt_s1) * CUBE_W'(u_s1);
	assign d_d = CUBE_W'(tt_s1) * CUBE_W'(t_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			u_s1   <= u_d;
			t_s1   <= in_t;
			uu_s1  <= SQ_W'(u_d) * SQ_W'(u_d);
			tt_s1  <= SQ_W'(in_t) * SQ_W'(in_t);
			tag_s1 <= in_tag;
			pts_s1 <= in_pts;
		end
		if (en_s2) begin
			a_s2   <= a_d[WGT_W-1:0];
			b_s2   <= b_d[WGT_W-1:0];
			c_s2   <= c_d[WGT_W-1:0];
			d_s2   <= d_d[WGT_W-1:0];
			tag_s2 <= tag_s1;
			pts_s2 <= pts_s1;
		end
		if (en_s3) begin
			w_s3[0] <= a_s2;
			w_s3[1] <= (b_s2 << 1) + b_s2;
			w_s3[2] <= (c_s2 << 1) + c_s2;
			w_s3[3] <= d_s2;
			tag_s3  <= tag_s2;
			pts_s3  <= pts_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_w     = w_s3;
	assign out_tag   = tag_s3;
	assign out_pts   = pts_s3;

endmodule
`default_nettype wire

// ===== rtl/core/bzs_blend.sv =====
// Three-stage pipeline blending the control points by the weights, with rounding.
`default_nettype none
module bzs_blend
	import bzs_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [3:0][WGT_W-1:0]             in_w,
	input  wire bzs_tag_t                          in_tag,
	input  wire logic [1:0][3:0][COORD_WIDTH-1:0]  in_pts,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [1:0][COORD_WIDTH-1:0]            out_coord,
	output bzs_tag_t                               out_tag
);

	localparam int HI_WGT_W = WGT_W - SPLIT_W;
	localparam int LO_W     = SPLIT_W + COORD_WIDTH;
	localparam int HI_W     = HI_WGT_W + COORD_WIDTH;
	localparam int SUM_LO_W = (LO_W + 2 > 2*SPLIT_W) ? LO_W + 3 : 2*SPLIT_W + 1;
	localparam int SUM_HI_W = HI_W + 2;
	localparam logic [SUM_LO_W-1:0] ROUND_HALF = SUM_LO_W'(1) << (2*SPLIT_W - 1);

	logic valid_s4, valid_s5, valid_s6;
	logic en_s4, en_s5, en_s6;

	logic [1:0][3:0][LO_W-1:0]     lo_s4;
	logic [1:0][3:0][HI_W-1:0]     hi_s4;
	logic [1:0][SUM_LO_W-1:0]      lo_sum_s5;
	logic [1:0][SUM_HI_W-1:0]      hi_sum_s5;
	logic [1:0][COORD_WIDTH-1:0]   coord_s6;
	bzs_tag_t tag_s4, tag_s5, tag_s6;

	logic [1:0][SUM_LO_W-1:0]    lo_sum_d;
	logic [1:0][SUM_HI_W-1:0]    hi_sum_d;
	logic [1:0][SUM_HI_W-1:0]    total_d;
	logic [1:0][COORD_WIDTH-1:0] coord_d;

	assign en_s6    = !valid_s6 || out_ready;
	assign en_s5    = !valid_s5 || en_s6;
	assign en_s4    = !valid_s4 || en_s5;
	assign in_ready = en_s4;

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			lo_sum_d[a] = ROUND_HALF;
			hi_sum_d[a] = '0;
			for (int k = 0; k < 4; k++) begin
				lo_sum_d[a] = lo_sum_d[a] + SUM_LO_W'(lo_s4[a][k]);
				hi_sum_d[a] = hi_sum_d[a] + SUM_HI_W'(hi_s4[a][k]);
			end
			total_d[a] = hi_sum_s5[a] + SUM_HI_W'(lo_sum_s5[a] >> SPLIT_W);
			coord_d[a] = total_d[a][SPLIT_W +: COORD_WIDTH]
				^ {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s4) valid_s4 <= in_valid;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int a = 0; a < 2; a++) begin
				for (int k = 0; k < 4; k++) begin
					lo_s4[a][k] <= LO_W'(in_w[k][SPLIT_W-1:0]) * LO_W'(in_pts[a][k]);
					hi_s4[a][k] <= HI_W'(in_w[k][WGT_W-1:SPLIT_W]) * HI_W'(in_pts[a][k]);
				end
			end
			tag_s4 <= in_tag;
		end
		if (en_s5) begin
			lo_sum_s5 <= lo_sum_d;
			hi_sum_s5 <= hi_sum_d;
			tag_s5    <= tag_s4;
		end
		if (en_s6) begin
			coord_s6 <= coord_d;
			tag_s6   <= tag_s5;
		end
	end

	assign out_valid = valid_s6;
	assign out_coord = coord_s6;
	assign out_tag   = tag_s6;

endmodule
`default_nettype wire

// ===== rtl/core/cubic_bezier_sampler.sv =====
// Top level of the cubic Bezier sampler: sequencer, weight pipeline and blend pipeline.
// Samples come from the sequencer's counter and are registered in the weight and blend stages.
// Throughput: one sample per cycle unless the output stalls; a segment holds num_points samples
// (clamped to 2..MAX_POINTS). The next request is taken on the last issue.
// Reset clears all valid bits and counters and sets num_points to 16 and t_step to 4369.
`default_nettype none
module cubic_bezier_sampler
	import bzs_pkg::*;
#(
	parameter int MAX_POINTS  = 64,
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
	input  wire logic [8*COORD_WIDTH-1:0]      s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// x_out, y_out, sample_index, zero fill
	output logic [((2*COORD_WIDTH+IDX_W+7)/8)*8-1:0] m_axis_tdata,
	output logic                               m_axis_tlast
);

	localparam int OUT_W   = ((2*COORD_WIDTH+IDX_W+7)/8)*8;
	localparam int OUT_PAD = OUT_W - 2*COORD_WIDTH - IDX_W;

	logic                             seq_valid, seq_ready;
	logic [T_W-1:0]                   seq_t;
	bzs_tag_t                         seq_tag;
	logic [1:0][3:0][COORD_WIDTH-1:0] seq_pts;
	bzs_seq_stat_t                    seq_stat;

	logic                             wgt_valid, wgt_ready;
	logic [3:0][WGT_W-1:0]            wgt_w;
	bzs_tag_t                         wgt_tag;
	logic [1:0][3:0][COORD_WIDTH-1:0] wgt_pts;

	logic [1:0][COORD_WIDTH-1:0]      blend_coord;
	bzs_tag_t                         blend_tag;
	logic                             in_acc;

	assign cfg_ready = 1'b1;
	assign in_acc    = s_axis_tvalid && s_axis_tready;

	bzs_seq #(
		.MAX_POINTS  (MAX_POINTS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (seq_valid),
		.out_ready (seq_ready),
		.out_t     (seq_t),
		.out_tag   (seq_tag),
		.out_pts   (seq_pts),
		.stat      (seq_stat)
	);

	bzs_weight #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seq_valid),
		.in_ready  (seq_ready),
		.in_t      (seq_t),
		.in_tag    (seq_tag),
		.in_pts    (seq_pts),
		.out_valid (wgt_valid),
		.out_ready (wgt_ready),
		.out_w     (wgt_w),
		.out_tag   (wgt_tag),
		.out_pts   (wgt_pts)
	);

	bzs_blend #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (wgt_valid),
		.in_ready  (wgt_ready),
		.in_w      (wgt_w),
		.in_tag    (wgt_tag),
		.in_pts    (wgt_pts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_coord (blend_coord),
		.out_tag   (blend_tag)
	);

	assign m_axis_tdata = {{OUT_PAD{1'b0}}, blend_tag.idx, blend_coord[1], blend_coord[0]};
	assign m_axis_tlast = blend_tag.last;

	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (blend_tag.idx == '0) |-> !m_axis_tlast)
		else $error("first sample of a segment flagged as last");

	a_accept_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (!seq_stat.busy || (seq_stat.fire && seq_stat.last)))
		else $error("request accepted while a segment is still issuing");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		seq_stat.fire && seq_stat.last && !in_acc |=> !seq_stat.busy)
		else $error("sequencer still busy after its last sample");

	a_issue_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		seq_stat.fire && !seq_stat.last && !in_acc |=> seq_stat.busy
			&& (seq_tag.idx == $past(seq_tag.idx) + IDX_W'(1)))
		else $error("sample index did not advance by one");

endmodule
`default_nettype wire

// ===== tb/cubic_bezier_sampler_test.sv =====
// Self-checking testbench of the cubic Bezier sampler: directed corners, output stall, random segments.
`default_nettype none
module cubic_bezier_sampler_test;
	import bzs_pkg::*;

	localparam int MAX_SAMPLES    = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 36;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP   = 8'hFF;

	typedef logic signed [15:0]       coord_t;
	typedef logic [7:0][15:0]         segment_t;
	typedef logic signed [95:0]       wide_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_word_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [IDX_W-1:0]   idx;
		logic               last;
	} sample_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic m_axis_tlast;

	sample_t pending[$];
	logic [NPTS_W-1:0] npts_reg = NPTS_RESET;
	logic [T_W-1:0]    tstep_reg = TSTEP_RESET;
	bit steady = 1'b0;
	int unsigned hold_off = 0;
	int unsigned errors = 0;
	int unsigned segments = 0;
	int unsigned samples = 0;
	int unsigned reg_writes = 0;

	cubic_bezier_sampler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int unsigned points_used(input logic [NPTS_W-1:0] n);
		if (n < 2)
			return 2;
		if (n > MAX_SAMPLES)
			return MAX_SAMPLES;
		return n;
	endfunction

	function automatic void predict_samples(input segment_t seg);
		int unsigned count, t_next, t, i, k;
		wide_t tt, uu, sx, sy;
		wide_t w [4];
		sample_t s;
		count = points_used(npts_reg);
		t_next = 0;
		for (i = 0; i < count; i++) begin
			t = (i == count - 1) ? T_ONE : t_next;
			tt = wide_t'(t);
			uu = wide_t'(T_ONE - t);
			w[0] = uu * uu * uu;
			w[1] = wide_t'(3) * uu * uu * tt;
			w[2] = wide_t'(3) * uu * tt * tt;
			w[3] = tt * tt * tt;
			sx = wide_t'(1) <<< 47;
			sy = wide_t'(1) <<< 47;
			for (k = 0; k < 4; k++) begin
				sx = sx + w[k] * wide_t'($signed(seg[2*k]));
				sy = sy + w[k] * wide_t'($signed(seg[2*k+1]));
			end
			sx = sx >>> 48;
			sy = sy >>> 48;
			s.x = sx[15:0];
			s.y = sy[15:0];
			s.idx = i[IDX_W-1:0];
			s.last = (i == count - 1);
			pending.insert(pending.size(), s);
			t_next = t_next + tstep_reg;
			if (t_next > T_ONE)
				t_next = T_ONE;
		end
	endfunction

	function automatic coord_t random_coord();
		case ($urandom_range(0, 15))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			3: return '1;
			default: return coord_t'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic segment_t random_segment();
		segment_t seg;
		int k;
		for (k = 0; k < 8; k++)
			seg[k] = random_coord();
		return seg;
	endfunction

	task automatic send_segment(input segment_t seg);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= seg;
		do @(posedge clk); while (!s_axis_tready);
		segments++;
		predict_samples(seg);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input cfg_word_t value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		case (index)
			CFG_NUM_POINTS: npts_reg = value[NPTS_W-1:0];
			CFG_T_STEP:     tstep_reg = value[T_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input cfg_word_t npts_word, input cfg_word_t step_word,
			input bit spare);
		wait_drained();
		if (spare) begin
			put_reg(CFG_SPARE, cfg_word_t'($urandom_range(0, 17'h1FFFF)));
			put_reg(CFG_TOP, '1);
		end
		put_reg(CFG_NUM_POINTS, npts_word);
		put_reg(CFG_T_STEP, step_word);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_extremes();
		send_segment({8{16'h8000}});
		send_segment({8{16'h7FFF}});
		send_segment({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h8000});
		send_segment({16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
			16'h7FFF});
		send_segment({16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF,
			16'h0000});
		wait_drained();
	endtask

	task automatic test_point_counts();
		load_settings(cfg_word_t'(2), cfg_word_t'(65536), 1'b0);
		send_segment(random_segment());
		load_settings(cfg_word_t'(64), cfg_word_t'(1040), 1'b1);
		send_segment(random_segment());
		load_settings(cfg_word_t'(0), cfg_word_t'(65536), 1'b0);
		send_segment(random_segment());
		load_settings(cfg_word_t'(1), cfg_word_t'(0), 1'b0);
		send_segment(random_segment());
		load_settings(cfg_word_t'(127), cfg_word_t'(1040), 1'b0);
		send_segment(random_segment());
		load_settings(cfg_word_t'(65), cfg_word_t'(1024), 1'b0);
		send_segment(random_segment());
		load_settings(cfg_word_t'(17'h1FF83), cfg_word_t'(32768), 1'b0);
		send_segment(random_segment());
		wait_drained();
	endtask

	task automatic test_step_corners();
		load_settings(cfg_word_t'(16), cfg_word_t'(0), 1'b0);
		send_segment(random_segment());
		load_settings(cfg_word_t'(16), cfg_word_t'(65536), 1'b0);
		send_segment(random_segment());
		load_settings(cfg_word_t'(9), cfg_word_t'(17'h1FFFF), 1'b0);
		send_segment(random_segment());
		load_settings(cfg_word_t'(64), cfg_word_t'(1), 1'b0);
		send_segment(random_segment());
		load_settings(cfg_word_t'(33), cfg_word_t'(2100), 1'b0);
		send_segment(random_segment());
		wait_drained();
	endtask

	task automatic test_backpressure();
		int i;
		load_settings(cfg_word_t'(24), cfg_word_t'(2849), 1'b0);
		steady = 1'b1;
		hold_off = LONG_HOLD;
		for (i = 0; i < 12; i++)
			send_segment(random_segment());
		wait_drained();
		steady = 1'b0;
	endtask

	task automatic test_random();
		int unsigned phase, i, n, n_eff, step;
		cfg_word_t npts_word;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: n = $urandom_range(2, 12);
				6, 7: n = $urandom_range(13, MAX_SAMPLES);
				8: n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(65, 127);
				default: n = MAX_SAMPLES;
			endcase
			n_eff = points_used(n[NPTS_W-1:0]);
			case ($urandom_range(0, 5))
				0, 1, 2: step = (65536 + (n_eff - 1) / 2) / (n_eff - 1);
				3: step = 65536 / (n_eff - 1) + $urandom_range(0, 64);
				4: step = $urandom_range(0, 17'h1FFFF);
				default: step = $urandom_range(0, 1) ? 0 : 65536;
			endcase
			npts_word = cfg_word_t'(n);
			if (phase % 2 == 1)
				npts_word[CFG_DATA_W-1:NPTS_W] =
					(CFG_DATA_W-NPTS_W)'($urandom_range(0, 1023));
			load_settings(npts_word, cfg_word_t'(step), phase % 3 == 0);
			steady = (phase == 2 || phase == 5);
			for (i = 0; i < PHASE_ITEMS; i++)
				send_segment(random_segment());
			wait_drained();
			steady = 1'b0;
		end
	endtask

	initial begin : result_sink
		int unsigned pause;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pause = steady ? 0 : $urandom_range(0, 19);
			if (hold_off != 0) begin
				pause = hold_off;
				hold_off = 0;
			end
			if (pause != 0) begin
				m_axis_tready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin : result_check
		sample_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending.size() == 0) begin
				errors++;
				$error("sample with no segment pending: tdata %h", m_axis_tdata);
			end else begin
				want = pending.pop_front();
				samples++;
				if (m_axis_tdata[15:0] !== want.x) begin
					errors++;
					$error("x_out: expected %0d, got %0d", want.x, $signed(m_axis_tdata[15:0]));
				end
				if (m_axis_tdata[31:16] !== want.y) begin
					errors++;
					$error("y_out: expected %0d, got %0d", want.y, $signed(m_axis_tdata[31:16]));
				end
				if (m_axis_tdata[37:32] !== want.idx) begin
					errors++;
					$error("sample_index: expected %0d, got %0d", want.idx, m_axis_tdata[37:32]);
				end
				if (m_axis_tlast !== want.last) begin
					errors++;
					$error("is_last: expected %0d, got %0d", want.last, m_axis_tlast);
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_point_counts();
		test_step_corners();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (16) @(posedge clk);
		$display("Checked %0d samples from %0d segments over %0d register writes,",
			samples, segments, reg_writes);
		$display("with clamped point counts, zero and saturating steps and a long output stall.");
		if (errors == 0 && pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
